### sv/assert_macros.svh
// Assertion helpers used by the rotator core.
// Both macros expect signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the cycle after the antecedent, outside reset.
`define AR3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after every reset cycle.
`define AR3_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### sv/ar3_pkg.sv
package ar3_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_W          = 16;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int MAT_FRAC        = 20;
  localparam int NUM_CH          = 7;
  localparam int CW              = 32;
  localparam int MAT_W           = 28;
  localparam int REG_W           = 64;
  localparam int ADDR_W          = 6;
  localparam int SETTLE_CYCLES   = 4;
  localparam int SETTLE_W        = 3;
  // Growth of a sample through one pairwise rotation.
  localparam int ROT_GROW        = COEF_W + 1 - COEF_FRAC_BITS;

  localparam logic signed [CW-1:0] ONE       = 32'sd1048576;
  localparam logic signed [CW-1:0] K_SQRT3_2 = 32'sd1284238;
  localparam logic signed [CW-1:0] K_SQRT15  = 32'sd4061117;
  localparam logic signed [CW-1:0] K_SQRT5_2 = 32'sd1657944;

  localparam logic [47:0] COS_RESET = 48'h4000_4000_4000;

  typedef enum logic [2:0] {
    REG_ALPHA_COS = 3'd0,
    REG_ALPHA_SIN = 3'd1,
    REG_BETA_COS  = 3'd2,
    REG_BETA_SIN  = 3'd3,
    REG_GAMMA_COS = 3'd4,
    REG_GAMMA_SIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } rot_ctl_t;

  // Q2.14 field k of a packed register, widened to Q.20.
  function automatic logic signed [CW-1:0] coef_q20(input logic [47:0] reg_v,
                                                    input int unsigned k);
    logic [COEF_W-1:0] f;
    f = reg_v[COEF_W*k +: COEF_W];
    return signed'({{(CW-COEF_W-(MAT_FRAC-COEF_FRAC_BITS)){f[COEF_W-1]}}, f,
                    {(MAT_FRAC-COEF_FRAC_BITS){1'b0}}});
  endfunction

  // Rounded shift right, ties toward plus infinity.
  function automatic logic signed [CW-1:0] rnd_sh(input logic signed [CW-1:0] v,
                                                  input int unsigned n);
    logic signed [CW-1:0] half;
    half = CW'(1) <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  // Q.20 by Q.20 product, rounded back to Q.20.
  function automatic logic signed [CW-1:0] qm(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    logic signed [63:0] p;
    logic signed [63:0] half;
    half = 64'sd1 <<< (MAT_FRAC - 1);
    p = 64'(a) * 64'(b);
    p = (p + half) >>> MAT_FRAC;
    return p[CW-1:0];
  endfunction

endpackage

### sv/ambisonic_order3_rotator_core.sv
// Order-3 ambisonic rotator. Each input transaction carries one sample of the
// seven order-3 channels (signed Q1.23) and yields one output transaction with
// the seven channels rotated by the Euler angles held in the registers.
// Both streams use valid/ready. The rotation angles are programmed as packed
// Q2.14 cosines and sines through the APB-style port, registers at 8-byte
// spacing; write them only while no transaction is in flight.
// The datapath is a seven-stage pipeline: two stages for the alpha pairwise
// mixing, two for the beta matrix (products, then sum and rounding), two for
// the gamma mixing and one for saturation into the output register. One
// sample is taken every cycle, set by the one-per-cycle advance of every stage,
// except while the pipe is full and stalled or the coefficient pipeline refills.
// The beta matrix is derived from the beta registers by a separate three-stage
// coefficient pipeline; after reset and after any register write the input
// side holds ready low while that pipeline refills.
// When the receiver stalls, each full stage holds while the one after it cannot load,
// empty stages keep filling, and input ready drops only once the pipe is full.
// Reset clears all valid bits and returns every cosine to 1.0 and sine to 0.
`include "assert_macros.svh"

module ambisonic_order3_rotator_core #(
  parameter int SAMPLE_BITS = ar3_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ar3_pkg::ADDR_W-1:0] paddr,
  input  logic [ar3_pkg::REG_W-1:0]  pwdata,
  output logic [ar3_pkg::REG_W-1:0]  prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_ch1,
  input  logic signed [SAMPLE_BITS-1:0] in_ch2,
  input  logic signed [SAMPLE_BITS-1:0] in_ch3,
  input  logic signed [SAMPLE_BITS-1:0] in_ch4,
  input  logic signed [SAMPLE_BITS-1:0] in_ch5,
  input  logic signed [SAMPLE_BITS-1:0] in_ch6,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_ch0,
  output logic signed [SAMPLE_BITS-1:0] out_ch1,
  output logic signed [SAMPLE_BITS-1:0] out_ch2,
  output logic signed [SAMPLE_BITS-1:0] out_ch3,
  output logic signed [SAMPLE_BITS-1:0] out_ch4,
  output logic signed [SAMPLE_BITS-1:0] out_ch5,
  output logic signed [SAMPLE_BITS-1:0] out_ch6
);
  import ar3_pkg::*;

  // Widths along the datapath: after alpha, beta products, beta sum, gamma.
  localparam int AW    = SAMPLE_BITS + ROT_GROW;
  localparam int BPW   = MAT_W + AW;
  localparam int ACC_W = BPW + 3;
  localparam int TW    = ACC_W - MAT_FRAC;
  localparam int GW    = TW + ROT_GROW;
  localparam int NSTG  = 7;
  localparam logic signed [GW-1:0] SAT_HI = GW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [GW-1:0] SAT_LO = -SAT_HI - GW'(1);

  // Configuration registers.
  logic [47:0] alpha_cos, alpha_sin, beta_cos, gamma_cos, gamma_sin;
  logic [31:0] beta_sin;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [SETTLE_W-1:0] settle;

  // Pipeline control: vld[k] marks stage k full, adv[k] lets stage k load.
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] adv;
  logic            in_take;

  logic signed [SAMPLE_BITS-1:0] x_in [NUM_CH];
  logic signed [AW-1:0]    a_q  [NUM_CH];
  logic signed [MAT_W-1:0] mat  [NUM_CH][NUM_CH];
  logic signed [BPW-1:0]   bp   [NUM_CH][NUM_CH];
  logic signed [ACC_W-1:0] acc  [NUM_CH];
  logic signed [TW-1:0]    t_q  [NUM_CH];
  logic signed [GW-1:0]    g_q  [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] sat_next [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] out_q    [NUM_CH];
  rot_ctl_t alpha_ctl, gamma_ctl;

  // ---------------------------------------------------------------------------
  // Register port. Writes complete in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_cos <= COS_RESET;
      alpha_sin <= '0;
      beta_cos  <= COS_RESET;
      beta_sin  <= '0;
      gamma_cos <= COS_RESET;
      gamma_sin <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHA_COS: alpha_cos <= pwdata[47:0];
        REG_ALPHA_SIN: alpha_sin <= pwdata[47:0];
        REG_BETA_COS:  beta_cos  <= pwdata[47:0];
        REG_BETA_SIN:  beta_sin  <= pwdata[31:0];
        REG_GAMMA_COS: gamma_cos <= pwdata[47:0];
        REG_GAMMA_SIN: gamma_sin <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHA_COS: prdata = REG_W'(alpha_cos);
      REG_ALPHA_SIN: prdata = REG_W'(alpha_sin);
      REG_BETA_COS:  prdata = REG_W'(beta_cos);
      REG_BETA_SIN:  prdata = REG_W'(beta_sin);
      REG_GAMMA_COS: prdata = REG_W'(gamma_cos);
      REG_GAMMA_SIN: prdata = REG_W'(gamma_sin);
      default:       prdata = '0;
    endcase
  end

  // The beta coefficient pipeline must refill before it reflects new values,
  // so input is held off after reset and after each register write.
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= SETTLE_W'(SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage advance. A stage loads when it is empty or its contents move on.
  // ---------------------------------------------------------------------------
  always_comb begin
    adv[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[1] && (settle == '0);
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_take;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: alpha rotation.
  // ---------------------------------------------------------------------------
  assign x_in[0] = in_ch0;
  assign x_in[1] = in_ch1;
  assign x_in[2] = in_ch2;
  assign x_in[3] = in_ch3;
  assign x_in[4] = in_ch4;
  assign x_in[5] = in_ch5;
  assign x_in[6] = in_ch6;

  assign alpha_ctl = '{load_prod: adv[1], load_sum: adv[2]};

  ar3_pair_rot #(.IN_W(SAMPLE_BITS), .OUT_W(AW)) u_alpha (
    .clk     (clk),
    .ctl     (alpha_ctl),
    .cos_reg (alpha_cos),
    .sin_reg (alpha_sin),
    .x       (x_in),
    .y       (a_q)
  );

  // ---------------------------------------------------------------------------
  // Stages 3-4: beta matrix. Entries outside the two diagonal blocks are zero.
  // ---------------------------------------------------------------------------
  ar3_beta_coef u_beta_coef (
    .clk          (clk),
    .beta_cosines (beta_cos),
    .beta_sines   (beta_sin),
    .mat          (mat)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        for (int j = 0; j < NUM_CH; j++) begin
          bp[i][j] <= mat[i][j] * a_q[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      acc[i] = ACC_W'(1) <<< (MAT_FRAC - 1);
      for (int j = 0; j < NUM_CH; j++) begin
        acc[i] = acc[i] + ACC_W'(bp[i][j]);
      end
      acc[i] = acc[i] >>> MAT_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < NUM_CH; i++) begin
        t_q[i] <= acc[i][TW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5-6: gamma rotation; stage 7: saturation into the output register.
  // ---------------------------------------------------------------------------
  assign gamma_ctl = '{load_prod: adv[5], load_sum: adv[6]};

  ar3_pair_rot #(.IN_W(TW), .OUT_W(GW)) u_gamma (
    .clk     (clk),
    .ctl     (gamma_ctl),
    .cos_reg (gamma_cos),
    .sin_reg (gamma_sin),
    .x       (t_q),
    .y       (g_q)
  );

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (g_q[i] > SAT_HI) begin
        sat_next[i] = SAT_HI[SAMPLE_BITS-1:0];
      end else if (g_q[i] < SAT_LO) begin
        sat_next[i] = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        sat_next[i] = g_q[i][SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      out_q <= sat_next;
    end
  end

  assign out_valid = vld[NSTG];
  assign out_ch0   = out_q[0];
  assign out_ch1   = out_q[1];
  assign out_ch2   = out_q[2];
  assign out_ch3   = out_q[3];
  assign out_ch4   = out_q[4];
  assign out_ch5   = out_q[5];
  assign out_ch6   = out_q[6];

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `AR3_ASSERT_NEXT(a_cfg_holds_input, cfg_wr, !in_ready, "input open after register write")
  `AR3_ASSERT_NEXT(a_take_fills_stage1, in_take, vld[1], "accepted transaction lost")
  `AR3_ASSERT_AFTER_RST(a_reset_empty, vld == '0 && !in_ready, "pipeline not empty after reset")

endmodule

### sv/ar3_pair_rot.sv
module ar3_pair_rot #(
  parameter int IN_W  = 27,
  parameter int OUT_W = 30
) (
  input  logic                  clk,
  input  ar3_pkg::rot_ctl_t     ctl,
  input  logic [47:0]           cos_reg,
  input  logic [47:0]           sin_reg,
  input  logic signed [IN_W-1:0]  x [ar3_pkg::NUM_CH],
  output logic signed [OUT_W-1:0] y [ar3_pkg::NUM_CH]
);
  import ar3_pkg::*;

  localparam int PW = IN_W + COEF_W;
  localparam int SW = PW + 2;

  logic signed [COEF_W-1:0] cf [3];
  logic signed [COEF_W-1:0] sf [3];
  logic signed [PW-1:0] p_lc [3];
  logic signed [PW-1:0] p_hs [3];
  logic signed [PW-1:0] p_hc [3];
  logic signed [PW-1:0] p_ls [3];
  logic signed [IN_W-1:0] mid_q;
  logic signed [SW-1:0] d_lo [3];
  logic signed [SW-1:0] d_hi [3];
  logic signed [SW-1:0] half;

  // Pair k mixes channels k and 6-k with the (3-k)-fold angle.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cf[k] = signed'(cos_reg[COEF_W*(2-k) +: COEF_W]);
      sf[k] = signed'(sin_reg[COEF_W*(2-k) +: COEF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      for (int k = 0; k < 3; k++) begin
        p_lc[k] <= x[k] * cf[k];
        p_hs[k] <= x[6-k] * sf[k];
        p_hc[k] <= x[6-k] * cf[k];
        p_ls[k] <= x[k] * sf[k];
      end
      mid_q <= x[3];
    end
  end

  always_comb begin
    half = SW'(1) <<< (COEF_FRAC_BITS - 1);
    for (int k = 0; k < 3; k++) begin
      d_lo[k] = (SW'(p_lc[k]) - SW'(p_hs[k]) + half) >>> COEF_FRAC_BITS;
      d_hi[k] = (SW'(p_hc[k]) + SW'(p_ls[k]) + half) >>> COEF_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      for (int k = 0; k < 3; k++) begin
        y[k]   <= d_lo[k][OUT_W-1:0];
        y[6-k] <= d_hi[k][OUT_W-1:0];
      end
      y[3] <= OUT_W'(mid_q);
    end
  end

endmodule

### sv/ar3_beta_coef.sv
module ar3_beta_coef (
  input  logic        clk,
  input  logic [47:0] beta_cosines,
  input  logic [31:0] beta_sines,
  output logic signed [ar3_pkg::MAT_W-1:0] mat [ar3_pkg::NUM_CH][ar3_pkg::NUM_CH]
);
  import ar3_pkg::*;

  logic signed [CW-1:0] c1, c2, c3, s1, s3;
  // First stage.
  logic signed [CW-1:0] r1_c1, r1_c2, r1_s1, r1_cs, r1_ss;
  logic signed [CW-1:0] r1_p33, r1_p34, r1_p54, r1_q45, r1_q56;
  logic signed [CW-1:0] r1_m00, r1_m22, r1_m44, r1_m55, r1_m66;
  // Second stage.
  logic signed [CW-1:0] r2_sss, r2_css, r2_m10, r2_m12, r2_m02, r2_m45, r2_m56;
  logic signed [CW-1:0] r2_m33, r2_m34, r2_m54, r2_c2;
  logic signed [CW-1:0] r2_m00, r2_m22, r2_m44, r2_m55, r2_m66;
  logic signed [CW-1:0] m35, m46, m36;
  logic signed [MAT_W-1:0] mat_next [NUM_CH][NUM_CH];

  always_comb begin
    c1 = coef_q20(beta_cosines, 0);
    c2 = coef_q20(beta_cosines, 1);
    c3 = coef_q20(beta_cosines, 2);
    s1 = coef_q20({16'h0, beta_sines}, 0);
    s3 = coef_q20({16'h0, beta_sines}, 1);
  end

  always_ff @(posedge clk) begin
    r1_c1  <= c1;
    r1_c2  <= c2;
    r1_s1  <= s1;
    r1_cs  <= qm(c1, s1);
    r1_ss  <= qm(s1, s1);
    r1_p33 <= qm(c1, 15 * c2 - ONE);
    r1_p34 <= qm(K_SQRT3_2, s1 + 5 * s3);
    r1_p54 <= qm(K_SQRT5_2, s1 - 3 * s3);
    r1_q45 <= qm(K_SQRT5_2, ONE + 3 * c2);
    r1_q56 <= qm(K_SQRT3_2, 3 * ONE + c2);
    r1_m00 <= rnd_sh(5 * ONE + 3 * c2, 3);
    r1_m22 <= rnd_sh(3 * ONE + 5 * c2, 3);
    r1_m44 <= rnd_sh(c1 + 15 * c3, 4);
    r1_m55 <= rnd_sh(5 * c1 + 3 * c3, 3);
    r1_m66 <= rnd_sh(15 * c1 + c3, 4);
  end

  always_ff @(posedge clk) begin
    r2_sss <= qm(r1_ss, r1_s1);
    r2_css <= qm(r1_c1, r1_ss);
    r2_m10 <= qm(K_SQRT3_2, r1_cs);
    r2_m12 <= -qm(K_SQRT5_2, r1_cs);
    r2_m02 <= rnd_sh(qm(K_SQRT15, r1_ss), 2);
    r2_m45 <= rnd_sh(qm(r1_q45, r1_s1), 2);
    r2_m56 <= rnd_sh(qm(r1_q56, r1_s1), 2);
    r2_m33 <= rnd_sh(r1_p33, 2);
    r2_m34 <= rnd_sh(r1_p34, 3);
    r2_m54 <= rnd_sh(r1_p54, 3);
    r2_c2  <= r1_c2;
    r2_m00 <= r1_m00;
    r2_m22 <= r1_m22;
    r2_m44 <= r1_m44;
    r2_m55 <= r1_m55;
    r2_m66 <= r1_m66;
  end

  always_comb begin
    m35 = rnd_sh(qm(K_SQRT15, r2_css), 1);
    m46 = rnd_sh(qm(K_SQRT15, r2_css), 2);
    m36 = rnd_sh(qm(K_SQRT5_2, r2_sss), 1);
    for (int i = 0; i < NUM_CH; i++) begin
      for (int j = 0; j < NUM_CH; j++) begin
        mat_next[i][j] = '0;
      end
    end
    mat_next[0][0] = r2_m00[MAT_W-1:0];
    mat_next[0][1] = MAT_W'(-r2_m10);
    mat_next[0][2] = r2_m02[MAT_W-1:0];
    mat_next[1][0] = r2_m10[MAT_W-1:0];
    mat_next[1][1] = r2_c2[MAT_W-1:0];
    mat_next[1][2] = r2_m12[MAT_W-1:0];
    mat_next[2][0] = r2_m02[MAT_W-1:0];
    mat_next[2][1] = r2_m12[MAT_W-1:0];
    mat_next[2][2] = r2_m22[MAT_W-1:0];
    mat_next[3][3] = r2_m33[MAT_W-1:0];
    mat_next[3][4] = r2_m34[MAT_W-1:0];
    mat_next[3][5] = m35[MAT_W-1:0];
    mat_next[3][6] = m36[MAT_W-1:0];
    mat_next[4][3] = MAT_W'(-r2_m34);
    mat_next[4][4] = r2_m44[MAT_W-1:0];
    mat_next[4][5] = r2_m45[MAT_W-1:0];
    mat_next[4][6] = m46[MAT_W-1:0];
    mat_next[5][3] = m35[MAT_W-1:0];
    mat_next[5][4] = r2_m54[MAT_W-1:0];
    mat_next[5][5] = r2_m55[MAT_W-1:0];
    mat_next[5][6] = r2_m56[MAT_W-1:0];
    mat_next[6][3] = MAT_W'(-m36);
    mat_next[6][4] = m46[MAT_W-1:0];
    mat_next[6][5] = MAT_W'(-r2_m56);
    mat_next[6][6] = r2_m66[MAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

endmodule

### dv/ambisonic_order3_rotator_core_tb.sv
module ambisonic_order3_rotator_core_tb;
  import ar3_pkg::*;

  localparam int SB = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_STALL = 300;
  // Index 6 and 7 decode to no register, so writes there must be dropped.
  localparam int NO_REG_LO = 6;
  localparam int NO_REG_HI = 7;

  typedef struct {
    logic signed [SB-1:0] ch [NUM_CH];
  } frame_t;

  logic clk;
  logic rst;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0] pwdata = '0;
  logic [REG_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic signed [SB-1:0] in_ch4 = '0, in_ch5 = '0, in_ch6 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB-1:0] out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6;

  ambisonic_order3_rotator_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2), .in_ch3(in_ch3),
    .in_ch4(in_ch4), .in_ch5(in_ch5), .in_ch6(in_ch6),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
    .out_ch4(out_ch4), .out_ch5(out_ch5), .out_ch6(out_ch6)
  );

  // Shadow copy of the rotation registers, indexed by register number.
  logic [REG_W-1:0] angle_regs [6];

  frame_t pending_samples[$];
  frame_t rotated_expected[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit send_hold = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of the rotation.
  // ---------------------------------------------------------------------------

  // Add half an LSB, then floor; ties therefore round toward plus infinity.
  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint mul_q20(longint a, longint b);
    return round_shift(a * b, MAT_FRAC);
  endfunction

  function automatic longint coef_field(logic [REG_W-1:0] r, int k);
    logic signed [15:0] f;
    f = r[16*k +: 16];
    return longint'(f);
  endfunction

  // Shared by the alpha and gamma stages. The outer pair 0/6 uses the
  // triple angle, 1/5 the double and 2/4 the single angle.
  function automatic void mix_pairs(input longint x [NUM_CH], output longint y [NUM_CH],
                                    input logic [REG_W-1:0] cr, input logic [REG_W-1:0] sr);
    longint c, s;
    for (int k = 0; k < 3; k++) begin
      c = coef_field(cr, 2 - k);
      s = coef_field(sr, 2 - k);
      y[k] = round_shift(x[k] * c - x[6-k] * s, COEF_FRAC_BITS);
      y[6-k] = round_shift(x[6-k] * c + x[k] * s, COEF_FRAC_BITS);
    end
    y[3] = x[3];
  endfunction

  function automatic frame_t rotate_frame(frame_t f);
    longint x [NUM_CH], a [NUM_CH], t [NUM_CH], g [NUM_CH];
    longint m [NUM_CH][NUM_CH];
    longint one, c1, c2, c3, s1, s3, cs, ss, sss, css, acc, hi, lo;
    longint k32, k15, k52;
    frame_t r;
    one = longint'(1) <<< MAT_FRAC;
    k32 = longint'(K_SQRT3_2);
    k15 = longint'(K_SQRT15);
    k52 = longint'(K_SQRT5_2);
    hi = (longint'(1) <<< (SB - 1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < NUM_CH; i++) x[i] = longint'(f.ch[i]);
    mix_pairs(x, a, angle_regs[REG_ALPHA_COS], angle_regs[REG_ALPHA_SIN]);

    // Beta coefficients widened from Q2.14 to Q.20.
    c1 = coef_field(angle_regs[REG_BETA_COS], 0) <<< (MAT_FRAC - COEF_FRAC_BITS);
    c2 = coef_field(angle_regs[REG_BETA_COS], 1) <<< (MAT_FRAC - COEF_FRAC_BITS);
    c3 = coef_field(angle_regs[REG_BETA_COS], 2) <<< (MAT_FRAC - COEF_FRAC_BITS);
    s1 = coef_field(angle_regs[REG_BETA_SIN], 0) <<< (MAT_FRAC - COEF_FRAC_BITS);
    s3 = coef_field(angle_regs[REG_BETA_SIN], 1) <<< (MAT_FRAC - COEF_FRAC_BITS);
    cs = mul_q20(c1, s1);
    ss = mul_q20(s1, s1);
    sss = mul_q20(ss, s1);
    css = mul_q20(c1, ss);
    for (int i = 0; i < NUM_CH; i++)
      for (int j = 0; j < NUM_CH; j++) m[i][j] = 0;

    m[0][0] = round_shift(5 * one + 3 * c2, 3);
    m[0][1] = -mul_q20(k32, cs);
    m[0][2] = round_shift(mul_q20(k15, ss), 2);
    m[1][0] = mul_q20(k32, cs);
    m[1][1] = c2;
    m[1][2] = -mul_q20(k52, cs);
    m[2][0] = m[0][2];
    m[2][1] = m[1][2];
    m[2][2] = round_shift(3 * one + 5 * c2, 3);
    m[3][3] = round_shift(mul_q20(c1, 15 * c2 - one), 2);
    m[3][4] = round_shift(mul_q20(k32, s1 + 5 * s3), 3);
    m[3][5] = round_shift(mul_q20(k15, css), 1);
    m[3][6] = round_shift(mul_q20(k52, sss), 1);
    m[4][3] = -m[3][4];
    m[4][4] = round_shift(c1 + 15 * c3, 4);
    m[4][5] = round_shift(mul_q20(mul_q20(k52, one + 3 * c2), s1), 2);
    m[4][6] = round_shift(mul_q20(k15, css), 2);
    m[5][3] = m[3][5];
    m[5][4] = round_shift(mul_q20(k52, s1 - 3 * s3), 3);
    m[5][5] = round_shift(5 * c1 + 3 * c3, 3);
    m[5][6] = round_shift(mul_q20(mul_q20(k32, 3 * one + c2), s1), 2);
    m[6][3] = -m[3][6];
    m[6][4] = m[4][6];
    m[6][5] = -m[5][6];
    m[6][6] = round_shift(15 * c1 + c3, 4);

    for (int i = 0; i < NUM_CH; i++) begin
      acc = 0;
      for (int j = 0; j < NUM_CH; j++) acc += m[i][j] * a[j];
      t[i] = round_shift(acc, MAT_FRAC);
    end

    mix_pairs(t, g, angle_regs[REG_GAMMA_COS], angle_regs[REG_GAMMA_SIN]);
    for (int i = 0; i < NUM_CH; i++) begin
      if (g[i] > hi) g[i] = hi;
      else if (g[i] < lo) g[i] = lo;
      r.ch[i] = g[i][SB-1:0];
    end
    return r;
  endfunction

  function automatic frame_t current_input();
    frame_t f;
    f.ch[0] = in_ch0; f.ch[1] = in_ch1; f.ch[2] = in_ch2; f.ch[3] = in_ch3;
    f.ch[4] = in_ch4; f.ch[5] = in_ch5; f.ch[6] = in_ch6;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver, monitor and watchdog.
  // ---------------------------------------------------------------------------

  // The driver only ever makes one assignment to in_valid per edge: a
  // transaction that is accepted is either replaced by the next sample or
  // followed by an idle cycle, decided in the same pass.
  always @(posedge clk) begin
    frame_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) rotated_expected.push_back(rotate_frame(current_input()));
      if (!send_hold && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_samples.pop_front();
        in_ch0 <= nxt.ch[0];
        in_ch1 <= nxt.ch[1];
        in_ch2 <= nxt.ch[2];
        in_ch3 <= nxt.ch[3];
        in_ch4 <= nxt.ch[4];
        in_ch5 <= nxt.ch[5];
        in_ch6 <= nxt.ch[6];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver serves long-stall requests by counting them down itself,
  // so the pipe fills and in_ready has to drop while the driver keeps going.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_requests != stall_served) begin
      stall_served <= stall_requests;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(string what, int unsigned chan,
                                 logic [SB-1:0] got, logic [SB-1:0] want);
    $display("mismatch at cycle %0d: %s ch%0d got %h expected %h",
             cycle_count, what, chan, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_t want;
    logic signed [SB-1:0] got [NUM_CH];
    if (!rst && out_valid && out_ready) begin
      got = '{out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5, out_ch6};
      if (rotated_expected.size() == 0) begin
        report_mismatch("unexpected output", 0, got[0], '0);
      end else begin
        want = rotated_expected.pop_front();
        for (int i = 0; i < NUM_CH; i++)
          if (got[i] !== want.ch[i]) report_mismatch("output", i, got[i], want.ch[i]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ambisonic_order3_rotator_core_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  task automatic write_reg(int idx, logic [REG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NO_REG_LO)
      angle_regs[idx] = (idx == REG_BETA_SIN) ? (value & 64'hFFFF_FFFF)
                                              : (value & 64'hFFFF_FFFF_FFFF);
  endtask

  // The pipeline is drained once nothing is queued, nothing is offered and
  // every expected output has been seen; a further wait then adds margin.
  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || rotated_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] to_q14(real v);
    int q;
    q = int'(v * 16384.0);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic write_angles(real al, real be, real ga);
    write_reg(REG_ALPHA_COS, {16'h0, to_q14($cos(3*al)), to_q14($cos(2*al)), to_q14($cos(al))});
    write_reg(REG_ALPHA_SIN, {16'h0, to_q14($sin(3*al)), to_q14($sin(2*al)), to_q14($sin(al))});
    write_reg(REG_BETA_COS, {16'h0, to_q14($cos(3*be)), to_q14($cos(2*be)), to_q14($cos(be))});
    write_reg(REG_BETA_SIN, {32'h0, to_q14($sin(3*be)), to_q14($sin(be))});
    write_reg(REG_GAMMA_COS, {16'h0, to_q14($cos(3*ga)), to_q14($cos(2*ga)), to_q14($cos(ga))});
    write_reg(REG_GAMMA_SIN, {16'h0, to_q14($sin(3*ga)), to_q14($sin(2*ga)), to_q14($sin(ga))});
  endtask

  // Every register gets the same raw value, which need not match any angle.
  task automatic write_all(logic [REG_W-1:0] value);
    for (int i = REG_ALPHA_COS; i <= REG_GAMMA_SIN; i++) write_reg(i, value);
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    return {$urandom(), $urandom()};
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int unsigned sel;
    sel = $urandom_range(9);
    for (int i = 0; i < NUM_CH; i++) begin
      case (sel)
        0: f.ch[i] = $urandom_range(1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
        1: f.ch[i] = SB'($signed($urandom_range(4095)) - 2048);
        default: f.ch[i] = SB'($urandom());
      endcase
    end
    return f;
  endfunction

  task automatic queue_uniform(logic signed [SB-1:0] v);
    frame_t f;
    for (int i = 0; i < NUM_CH; i++) f.ch[i] = v;
    pending_samples.push_back(f);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_samples.push_back(rand_frame());
  endtask

  // Zero, -1, sample-range extremes, an alternating pattern and single-channel
  // impulses, so each pair and the pass-through channel are seen alone.
  task automatic queue_directed();
    frame_t f;
    queue_uniform('0);
    queue_uniform({1'b0, {(SB-1){1'b1}}});
    queue_uniform({1'b1, {(SB-1){1'b0}}});
    queue_uniform(SB'(-1));
    for (int i = 0; i < NUM_CH; i++) f.ch[i] = i[0] ? {1'b1, {(SB-1){1'b0}}}
                                                   : {1'b0, {(SB-1){1'b1}}};
    pending_samples.push_back(f);
    for (int k = 0; k < NUM_CH; k++) begin
      for (int i = 0; i < NUM_CH; i++) f.ch[i] = '0;
      f.ch[k] = 24'sh40_0000;
      pending_samples.push_back(f);
    end
  endtask

  initial begin
    angle_regs[REG_ALPHA_COS] = COS_RESET;
    angle_regs[REG_ALPHA_SIN] = '0;
    angle_regs[REG_BETA_COS] = COS_RESET;
    angle_regs[REG_BETA_SIN] = '0;
    angle_regs[REG_GAMMA_COS] = COS_RESET;
    angle_regs[REG_GAMMA_SIN] = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First stretch: sender idles rarely, receiver often.
    send_idle_pct = 17;
    recv_idle_pct = 80;
    queue_directed();
    wait_drained();

    // Realistic angles.
    write_angles(0.7, 1.1, -2.3);
    queue_random(250);
    wait_drained();

    // Largest positive coefficients in every field, driving saturation.
    write_all(64'hFFFF_7FFF_7FFF_7FFF);
    queue_directed();
    queue_random(60);
    wait_drained();

    // Swap the idle pattern: sender idles often, receiver rarely.
    send_idle_pct = 80;
    recv_idle_pct = 17;
    write_all(64'h8000_8000_8000_8000);
    queue_random(150);
    wait_drained();

    // Raw random registers; writes to undecoded addresses must be dropped.
    for (int i = REG_ALPHA_COS; i <= REG_GAMMA_SIN; i++) write_reg(i, rand_reg());
    write_reg(NO_REG_LO, rand_reg());
    write_reg(NO_REG_HI, rand_reg());
    queue_random(200);
    wait_drained();

    // No idling at all, with a long receiver stall in the middle so the
    // pipeline backs up, then a sender pause until everything has drained.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_angles(-1.4, 2.9, 0.35);
    queue_random(200);
    repeat (20) @(posedge clk);
    stall_requests++;
    while (pending_samples.size() > 0) @(posedge clk);
    send_hold = 1'b1;
    queue_random(150);
    while (in_valid || rotated_expected.size() > 0) @(posedge clk);
    send_hold = 1'b0;
    wait_drained();

    write_reg(REG_BETA_SIN, rand_reg());
    write_reg(REG_GAMMA_COS, rand_reg());
    queue_random(150);
    wait_drained();

    if (mismatches == 0) begin
      $display("ambisonic_order3_rotator_core_tb passed");
    end else begin
      $display("ambisonic_order3_rotator_core_tb failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ar3_pkg.sv
sv/ar3_pair_rot.sv
sv/ar3_beta_coef.sv
sv/ambisonic_order3_rotator_core.sv
dv/ambisonic_order3_rotator_core_tb.sv
